/* rtl/tiny_z80_subset_executor_unit_assert.svh */
// assertion macros for the executor rtl
`ifndef TINY_Z80_SUBSET_EXECUTOR_UNIT_ASSERT_SVH
`define TINY_Z80_SUBSET_EXECUTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define TZSE_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("tzse assertion failed");
// consequent holds in the cycle after the antecedent
`define TZSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tzse assertion failed");
`else
`define TZSE_ASSERT_ALWAYS(label, expr)
`define TZSE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/tzse_pkg.sv */
// types, codes and helper functions for the z80 subset executor
`default_nettype none
package tzse_pkg;

  // register file indexes, order A F B C D E H L
  localparam logic [2:0] RI_A = 3'd0;
  localparam logic [2:0] RI_F = 3'd1;
  localparam logic [2:0] RI_B = 3'd2;
  localparam logic [2:0] RI_C = 3'd3;
  localparam logic [2:0] RI_D = 3'd4;
  localparam logic [2:0] RI_E = 3'd5;
  localparam logic [2:0] RI_H = 3'd6;
  localparam logic [2:0] RI_L = 3'd7;

  // decode phases
  localparam logic [1:0] PH_OPCODE  = 2'd0;
  localparam logic [1:0] PH_OPERAND = 2'd1;
  localparam logic [1:0] PH_JP_HIGH = 2'd2;

  // opcodes
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_INCR_ACC = 8'h3C;
  localparam logic [7:0] OP_LD_A     = 8'h3E;
  localparam logic [7:0] OP_LD_B     = 8'h06;
  localparam logic [7:0] OP_LD_C     = 8'h0E;
  localparam logic [7:0] OP_LD_D     = 8'h16;
  localparam logic [7:0] OP_LD_E     = 8'h1E;
  localparam logic [7:0] OP_LD_H     = 8'h26;
  localparam logic [7:0] OP_LD_L     = 8'h2E;
  localparam logic [7:0] OP_JP       = 8'hC3;
  localparam logic [7:0] OP_HALT     = 8'h76;
  localparam logic [7:0] OP_SWAP_AF  = 8'h08;
  localparam logic [7:0] OP_EXX      = 8'hD9;
  localparam logic [7:0] OP_ADD_AN   = 8'hC6;

  // flag bit masks
  localparam logic [7:0] FLAG_S  = 8'h80;
  localparam logic [7:0] FLAG_Z  = 8'h40;
  localparam logic [7:0] FLAG_H  = 8'h10;
  localparam logic [7:0] FLAG_PV = 8'h04;
  localparam logic [7:0] FLAG_C  = 8'h01;

  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // architectural state of the executor
  typedef struct packed {
    logic [15:0]      pc;
    logic [1:0]       phase;
    logic [7:0]       opcode;
    logic [7:0]       low_byte;
    logic             halted;
    logic [7:0][7:0]  main_regs;
    logic [7:0][7:0]  alt_regs;
  } tzse_state_t;

  // load target of an LD r,n opcode: {hit, index}
  function automatic logic [3:0] load_target(input logic [7:0] op);
    logic [3:0] res;
    res = 4'b0000;
    unique case (op)
      OP_LD_A: res = {1'b1, RI_A};
      OP_LD_B: res = {1'b1, RI_B};
      OP_LD_C: res = {1'b1, RI_C};
      OP_LD_D: res = {1'b1, RI_D};
      OP_LD_E: res = {1'b1, RI_E};
      OP_LD_H: res = {1'b1, RI_H};
      OP_LD_L: res = {1'b1, RI_L};
      default: res = 4'b0000;
    endcase
    return res;
  endfunction

  // 8-bit add with flags: {result, flags}
  function automatic logic [15:0] add_flags(input logic [7:0] a, input logic [7:0] n);
    logic [8:0] sum;
    logic [4:0] half;
    logic [7:0] r;
    logic [7:0] f;
    sum  = {1'b0, a} + {1'b0, n};
    half = {1'b0, a[3:0] & NIBBLE_MASK[3:0]} + {1'b0, n[3:0] & NIBBLE_MASK[3:0]};
    r    = sum[7:0];
    f    = 8'h00;
    if (r[7]) f = f | FLAG_S;
    if (r == 8'h00) f = f | FLAG_Z;
    if (half[4]) f = f | FLAG_H;
    if (!(a[7] ^ n[7]) && (a[7] ^ r[7])) f = f | FLAG_PV;
    if (sum[8]) f = f | FLAG_C;
    return {r, f};
  endfunction

endpackage
`default_nettype wire

/* rtl/tzse_exec.sv */
// decode and execute of one code byte against the current state
`default_nettype none
module tzse_exec
  import tzse_pkg::*;
#(
  parameter int unsigned PROGRAM_SIZE = 32768
) (
  input  tzse_state_t cur,
  input  logic [7:0]  code_byte,
  output tzse_state_t nxt,
  output logic        done,
  output logic        run_next
);

  localparam logic [16:0] PROG_LIMIT = 17'(PROGRAM_SIZE);

  logic        run_cur;
  logic [3:0]  tgt;
  logic [3:0]  tgt_op;
  logic [15:0] add_res;

  assign run_cur = !cur.halted && ({1'b0, cur.pc} < PROG_LIMIT);
  assign tgt     = load_target(cur.opcode);
  assign tgt_op  = load_target(code_byte);
  assign add_res = add_flags(cur.main_regs[RI_A], code_byte);

  // next state
  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (run_cur) begin
      nxt.pc = cur.pc + 16'd1;
      unique case (cur.phase)
        PH_OPERAND: begin
          if (cur.opcode == OP_JP) begin
            nxt.low_byte = code_byte;
            nxt.phase    = PH_JP_HIGH;
          end else begin
            if (cur.opcode == OP_ADD_AN) begin
              nxt.main_regs[RI_A] = add_res[15:8];
              nxt.main_regs[RI_F] = add_res[7:0];
            end else if (tgt[3]) begin
              nxt.main_regs[tgt[2:0]] = code_byte;
            end
            nxt.phase = PH_OPCODE;
            done      = 1'b1;
          end
        end
        PH_JP_HIGH: begin
          nxt.pc    = {code_byte, cur.low_byte};
          nxt.phase = PH_OPCODE;
          done      = 1'b1;
        end
        default: begin
          // opcode fetch, unused phase lands here too
          nxt.phase  = PH_OPCODE;
          nxt.opcode = code_byte;
          if (code_byte == OP_JP || code_byte == OP_ADD_AN || tgt_op[3]) begin
            nxt.phase = PH_OPERAND;
          end else begin
            unique case (code_byte)
              OP_INCR_ACC: nxt.main_regs[RI_A] = cur.main_regs[RI_A] + 8'd1;
              OP_HALT:     nxt.halted = 1'b1;
              OP_SWAP_AF: begin
                nxt.main_regs[RI_A] = cur.alt_regs[RI_A];
                nxt.main_regs[RI_F] = cur.alt_regs[RI_F];
                nxt.alt_regs[RI_A]  = cur.main_regs[RI_A];
                nxt.alt_regs[RI_F]  = cur.main_regs[RI_F];
              end
              OP_EXX: begin
                for (int i = 2; i < 8; i++) begin
                  nxt.main_regs[i] = cur.alt_regs[i];
                  nxt.alt_regs[i]  = cur.main_regs[i];
                end
              end
              default: ;
            endcase
            done = 1'b1;
          end
        end
      endcase
    end
  end

  assign run_next = !nxt.halted && ({1'b0, nxt.pc} < PROG_LIMIT);

endmodule
`default_nettype wire

/* rtl/tiny_z80_subset_executor_unit.sv */
// top level: input register, execute step, result register
// a byte waits in the input register until the result register can load
// throughput: one byte/cycle if no stall, set by the single execute step
// the input register refills while a result waits, so both sides overlap
// reset clears pc, decode phase, halt mark, both register banks and valids
`default_nettype none
`include "tiny_z80_subset_executor_unit_assert.svh"
module tiny_z80_subset_executor_unit
  import tzse_pkg::*;
#(
  parameter int unsigned PROGRAM_SIZE = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] fetch_addr,
  output logic        running,
  output logic        instr_done,
  output logic [7:0]  acc_value,
  output logic [7:0]  flag_value,
  output logic [7:0]  b_value,
  output logic [7:0]  c_value,
  output logic [7:0]  d_value,
  output logic [7:0]  e_value,
  output logic [7:0]  h_value,
  output logic [7:0]  l_value
);

  tzse_state_t st;
  tzse_state_t st_next;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        advance;
  logic        exec_go;
  logic        ex_done;
  logic        ex_run;

  assign advance  = !out_valid || out_ready;
  assign exec_go  = in_full && advance;
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_byte <= code_byte;
    end
  end

  tzse_exec #(
    .PROGRAM_SIZE(PROGRAM_SIZE)
  ) u_exec (
    .cur      (st),
    .code_byte(in_byte),
    .nxt      (st_next),
    .done     (ex_done),
    .run_next (ex_run)
  );

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (exec_go) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
    if (exec_go) begin
      fetch_addr <= st_next.pc;
      running    <= ex_run;
      instr_done <= ex_done;
      acc_value  <= st_next.main_regs[RI_A];
      flag_value <= st_next.main_regs[RI_F];
      b_value    <= st_next.main_regs[RI_B];
      c_value    <= st_next.main_regs[RI_C];
      d_value    <= st_next.main_regs[RI_D];
      e_value    <= st_next.main_regs[RI_E];
      h_value    <= st_next.main_regs[RI_H];
      l_value    <= st_next.main_regs[RI_L];
    end
  end

  // checks
  `TZSE_ASSERT_ALWAYS(a_phase_legal, st.phase <= PH_JP_HIGH)
  `TZSE_ASSERT_ALWAYS(a_ready_when_empty, out_valid || in_ready)
  `TZSE_ASSERT_NEXT(a_done_back_to_opcode, exec_go && ex_done, st.phase == PH_OPCODE)
  `TZSE_ASSERT_NEXT(a_halt_sticks, st.halted, st.halted)
  `TZSE_ASSERT_NEXT(a_stopped_pc_holds, exec_go && st.halted, $stable(st.pc))

endmodule
`default_nettype wire

/* bench/tzse_result_checker.sv */
// checker for the z80 subset executor: predicts each result and compares it
`default_nettype none
module tzse_result_checker
  import tzse_pkg::*;
#(
  parameter int unsigned PROGRAM_SIZE = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  code_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [15:0] fetch_addr,
  input  wire logic        running,
  input  wire logic        instr_done,
  input  wire logic [7:0]  acc_value,
  input  wire logic [7:0]  flag_value,
  input  wire logic [7:0]  b_value,
  input  wire logic [7:0]  c_value,
  input  wire logic [7:0]  d_value,
  input  wire logic [7:0]  e_value,
  input  wire logic [7:0]  h_value,
  input  wire logic [7:0]  l_value,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // visible cpu state after one code byte
  typedef struct packed {
    logic [15:0] addr;
    logic        run;
    logic        done;
    logic [7:0]  a;
    logic [7:0]  f;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
  } cpu_snapshot_t;

  // shadow copy of the executor state
  logic [15:0] pc = '0;
  logic [1:0]  phase = PH_OPCODE;
  logic [7:0]  opcode = '0;
  logic [7:0]  jp_low = '0;
  logic        halted = 1'b0;
  logic [7:0]  regs [8] = '{default: 8'h00};
  logic [7:0]  alts [8] = '{default: 8'h00};

  cpu_snapshot_t predicted_snapshots [$];
  int failures = 0;
  int outstanding = 0;

  assign fail_count = failures;
  assign pending    = outstanding;

  function automatic logic cpu_active();
    return !halted && (32'(pc) < PROGRAM_SIZE);
  endfunction

  // swap one main register with its alternate
  task automatic exchange_reg(input logic [2:0] idx);
    logic [7:0] tmp;
    tmp = regs[idx];
    regs[idx] = alts[idx];
    alts[idx] = tmp;
  endtask

  // run one code byte through the shadow cpu and give the visible state
  task automatic execute_code_byte(input logic [7:0] byte_in, output cpu_snapshot_t snap);
    logic       done;
    logic [8:0] sum;
    logic [4:0] half_sum;
    logic [7:0] acc;
    logic [7:0] flags;
    done = 1'b0;
    if (cpu_active()) begin
      pc = pc + 16'd1;
      case (phase)
        PH_OPERAND: begin
          if (opcode == OP_JP) begin
            jp_low = byte_in;
            phase = PH_JP_HIGH;
          end else begin
            case (opcode)
              OP_ADD_AN: begin
                acc = regs[RI_A];
                sum = {1'b0, acc} + {1'b0, byte_in};
                half_sum = {1'b0, acc[3:0]} + {1'b0, byte_in[3:0]};
                flags = 8'h00;
                if (sum[7]) flags = flags | FLAG_S;
                if (sum[7:0] == 8'h00) flags = flags | FLAG_Z;
                if (half_sum[4]) flags = flags | FLAG_H;
                // signed overflow: equal operand signs, different result sign
                if ((acc[7] == byte_in[7]) && (sum[7] != acc[7])) flags = flags | FLAG_PV;
                if (sum[8]) flags = flags | FLAG_C;
                regs[RI_A] = sum[7:0];
                regs[RI_F] = flags;
              end
              OP_LD_A: regs[RI_A] = byte_in;
              OP_LD_B: regs[RI_B] = byte_in;
              OP_LD_C: regs[RI_C] = byte_in;
              OP_LD_D: regs[RI_D] = byte_in;
              OP_LD_E: regs[RI_E] = byte_in;
              OP_LD_H: regs[RI_H] = byte_in;
              OP_LD_L: regs[RI_L] = byte_in;
              default: ;
            endcase
            phase = PH_OPCODE;
            done = 1'b1;
          end
        end
        PH_JP_HIGH: begin
          pc = {byte_in, jp_low};
          phase = PH_OPCODE;
          done = 1'b1;
        end
        default: begin
          // opcode fetch, the unused phase lands here too
          phase = PH_OPCODE;
          opcode = byte_in;
          case (byte_in)
            OP_JP, OP_ADD_AN, OP_LD_A, OP_LD_B, OP_LD_C, OP_LD_D, OP_LD_E, OP_LD_H,
            OP_LD_L: phase = PH_OPERAND;
            OP_INCR_ACC: regs[RI_A] = regs[RI_A] + 8'd1;
            OP_HALT: halted = 1'b1;
            OP_SWAP_AF: begin
              exchange_reg(RI_A);
              exchange_reg(RI_F);
            end
            OP_EXX: begin
              exchange_reg(RI_B);
              exchange_reg(RI_C);
              exchange_reg(RI_D);
              exchange_reg(RI_E);
              exchange_reg(RI_H);
              exchange_reg(RI_L);
            end
            default: ;
          endcase
          done = (phase == PH_OPCODE);
        end
      endcase
    end
    snap = '{addr: pc, run: cpu_active(), done: done, a: regs[RI_A], f: regs[RI_F],
             b: regs[RI_B], c: regs[RI_C], d: regs[RI_D], e: regs[RI_E],
             h: regs[RI_H], l: regs[RI_L]};
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // predict each accepted request, compare each accepted result
  always @(posedge clk) begin : watch
    cpu_snapshot_t want;
    cpu_snapshot_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        execute_code_byte(code_byte, want);
        predicted_snapshots.push_back(want);
        outstanding++;
      end
      if (out_valid && out_ready) begin
        got = '{addr: fetch_addr, run: running, done: instr_done, a: acc_value,
                f: flag_value, b: b_value, c: c_value, d: d_value, e: e_value,
                h: h_value, l: l_value};
        if (predicted_snapshots.size() == 0) begin
          failures++;
          $display("%0t: result with no request waiting, expected none, actual %h",
                   $time, got);
        end else begin
          want = predicted_snapshots.pop_front();
          outstanding--;
          check_field("fetch_addr", want.addr, got.addr);
          check_field("running", 16'(want.run), 16'(got.run));
          check_field("instr_done", 16'(want.done), 16'(got.done));
          check_field("acc_value", 16'(want.a), 16'(got.a));
          check_field("flag_value", 16'(want.f), 16'(got.f));
          check_field("b_value", 16'(want.b), 16'(got.b));
          check_field("c_value", 16'(want.c), 16'(got.c));
          check_field("d_value", 16'(want.d), 16'(got.d));
          check_field("e_value", 16'(want.e), 16'(got.e));
          check_field("h_value", 16'(want.h), 16'(got.h));
          check_field("l_value", 16'(want.l), 16'(got.l));
        end
      end
    end
  end

endmodule
`default_nettype wire

/* bench/tb_tiny_z80_subset_executor_unit.sv */
// testbench top: code byte stimulus, result sink, checker hookup and verdict
`default_nettype none
module tb_tiny_z80_subset_executor_unit;
  import tzse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PROGRAM_SIZE = 32768;
  // opcodes that the block treats as no-ops
  localparam logic [7:0] OP_SUBTRACT_B = 8'h90;
  localparam logic [7:0] OP_UNKNOWN    = 8'hFF;
  // random jumps stay low enough that straight-line code never runs off the end
  localparam int JP_PAGE_MAX = PROGRAM_SIZE / 256 - 16;
  localparam logic [15:0] LAST_ADDR = 16'(PROGRAM_SIZE - 1);
  localparam int ITEMS_PER_PHASE = 340;
  localparam int DRAIN_CYCLES = 8;

  // flag extremes, every opcode but halt, both no-op kinds, jp low byte first
  localparam logic [7:0] DIRECTED_PROG [31] = '{
    OP_LD_A, 8'hFF, OP_ADD_AN, 8'h01, OP_INCR_ACC,
    OP_LD_A, 8'h7F, OP_ADD_AN, 8'h01, OP_ADD_AN, 8'h80,
    OP_SWAP_AF,
    OP_LD_B, 8'hFF, OP_LD_C, 8'h00, OP_LD_D, 8'hA5, OP_LD_E, 8'h5A,
    OP_LD_H, 8'h80, OP_LD_L, 8'h01,
    OP_EXX, OP_NOP, OP_SUBTRACT_B, OP_UNKNOWN,
    OP_JP, 8'h34, 8'h12
  };

  localparam logic [7:0] KNOWN_OPS [14] = '{
    OP_NOP, OP_INCR_ACC, OP_LD_A, OP_LD_B, OP_LD_C, OP_LD_D, OP_LD_E,
    OP_LD_H, OP_LD_L, OP_JP, OP_SWAP_AF, OP_EXX, OP_ADD_AN, OP_SUBTRACT_B
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  code_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] fetch_addr;
  logic        running;
  logic        instr_done;
  logic [7:0]  acc_value;
  logic [7:0]  flag_value;
  logic [7:0]  b_value;
  logic [7:0]  c_value;
  logic [7:0]  d_value;
  logic [7:0]  e_value;
  logic [7:0]  h_value;
  logic [7:0]  l_value;
  int          fail_count;
  int          pending;
  int          src_idle_pct = 38;
  int          sink_idle_pct = 52;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tiny_z80_subset_executor_unit #(
    .PROGRAM_SIZE(PROGRAM_SIZE)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_byte  (code_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fetch_addr (fetch_addr),
    .running    (running),
    .instr_done (instr_done),
    .acc_value  (acc_value),
    .flag_value (flag_value),
    .b_value    (b_value),
    .c_value    (c_value),
    .d_value    (d_value),
    .e_value    (e_value),
    .h_value    (h_value),
    .l_value    (l_value)
  );

  tzse_result_checker #(
    .PROGRAM_SIZE(PROGRAM_SIZE)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_byte  (code_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fetch_addr (fetch_addr),
    .running    (running),
    .instr_done (instr_done),
    .acc_value  (acc_value),
    .flag_value (flag_value),
    .b_value    (b_value),
    .c_value    (c_value),
    .d_value    (d_value),
    .e_value    (e_value),
    .h_value    (h_value),
    .l_value    (l_value),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result sink with random stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // offer one code byte, idling first at random, and wait for the request to go
  task automatic send_byte(input logic [7:0] value);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_valid  <= 1'b1;
    code_byte <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // one instruction with random operands, opcode mostly from the known set
  task automatic send_instruction(output int nbytes);
    logic [7:0] op;
    if ($urandom_range(0, 9) < 7) begin
      op = KNOWN_OPS[$urandom_range(0, 13)];
    end else begin
      op = 8'($urandom_range(0, 255));
      if (op == OP_HALT) op = OP_NOP;
    end
    send_byte(op);
    nbytes = 1;
    case (op)
      OP_JP: begin
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, JP_PAGE_MAX)));
        nbytes = 3;
      end
      OP_ADD_AN, OP_LD_A, OP_LD_B, OP_LD_C, OP_LD_D, OP_LD_E, OP_LD_H, OP_LD_L: begin
        send_byte(8'($urandom_range(0, 255)));
        nbytes = 2;
      end
      default: ;
    endcase
  endtask

  // hold off new requests until every result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int nbytes;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed program
    foreach (DIRECTED_PROG[i]) send_byte(DIRECTED_PROG[i]);

    // random programs under three idle profiles
    for (int prof = 0; prof < 3; prof++) begin
      case (prof)
        1: begin
          src_idle_pct  = 52;
          sink_idle_pct = 38;
        end
        2: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        default: ;
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_instruction(nbytes);
        sent += nbytes;
      end
      wait_for_results();
    end

    // stop the cpu: halt, run off the end mid-instruction, or jump past the end
    case ($urandom_range(0, 2))
      0: send_byte(OP_HALT);
      1: begin
        send_byte(OP_JP);
        send_byte(LAST_ADDR[7:0]);
        send_byte(LAST_ADDR[15:8]);
        send_byte(OP_LD_B);
      end
      default: begin
        send_byte(OP_JP);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(PROGRAM_SIZE / 256, 255)));
      end
    endcase
    // bytes after the stop are ignored
    repeat (8) send_byte(8'($urandom_range(0, 255)));

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
